FILE: design/tris_pkg.sv
// Shared types for the two-room interval scheduler.
package tris_pkg;

   // Sequencer states: load, exchange sort, greedy scan, result
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_FETCH_I,
      ST_LOAD_I,
      ST_CMP,
      ST_WRITE_I,
      ST_SCAN_START,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

FILE: design/tris_req_if.sv
// Interval request channel: one interval word per handshake.
interface tris_req_if #(
   parameter int TIME_BITS = 20
);
   logic                 valid;
   logic                 ready;
   logic [TIME_BITS-1:0] start_time;
   logic [TIME_BITS-1:0] end_time;
   logic                 last;

   modport source (output valid, start_time, end_time, last, input ready);
   modport sink   (input valid, start_time, end_time, last, output ready);
endinterface

FILE: design/tris_rsp_if.sv
// Result channel: one count word per batch.
interface tris_rsp_if #(
   parameter int COUNT_BITS = 7
);
   logic                  valid;
   logic                  ready;
   logic [COUNT_BITS-1:0] scheduled_count;
   logic                  overflow;

   modport source (output valid, scheduled_count, overflow, input ready);
   modport sink   (input valid, scheduled_count, overflow, output ready);
endinterface

FILE: design/tris_pair_ram.sv
// Interval store: start and end packed per entry, one write and one registered read port.
module tris_pair_ram #(
   parameter int DEPTH     = 64,
   parameter int WIDTH     = 40,
   parameter int ADDR_BITS = 6
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic [ADDR_BITS-1:0] rd_addr,
   output logic [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one entry
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Register the read word
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/two_room_interval_scheduler_top.sv
// Top level of the two-room interval scheduler: batch load, exchange sort, greedy scan.
//
//  channel   dir   payload                          word meaning
//  req_chan  in    start_time, end_time, last       one interval; last closes the batch
//  rsp_chan  out   scheduled_count, overflow        one word per closed batch
//
// Loading stores one word per handshake. After the last word, the exchange sort runs on the single
// store (one write port, one registered read port) plus one comparator, then the greedy scan
// places the sorted entries over the two rooms.
// req_chan.ready is low from the last word until the result word is taken; the result holds in
// registers while rsp_chan.ready is low. Synchronous reset clears the sequencer and counters only.
module two_room_interval_scheduler_top
   import tris_pkg::*;
#(
   parameter int MAX_INTERVALS = 64,
   parameter int TIME_BITS     = 20
) (
   input  logic        clock,
   input  logic        reset,
   tris_req_if.sink    req_chan,
   tris_rsp_if.source  rsp_chan
);

   localparam int IDX_BITS = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
   localparam int CNT_BITS = $clog2(MAX_INTERVALS + 1);
   localparam int WORD_BITS = 2 * TIME_BITS;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   loaded_ff, loaded_in;
   logic                  overflow_ff, overflow_in;
   logic [CNT_BITS-1:0]   i_ff, i_in;
   logic [CNT_BITS-1:0]   j_ff, j_in;
   logic [CNT_BITS-1:0]   k_ff, k_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [TIME_BITS-1:0]  room1_ff, room1_in;
   logic [TIME_BITS-1:0]  room2_ff, room2_in;
   logic [WORD_BITS-1:0]  cur_ff, cur_in;

   logic                  wr_en;
   logic [IDX_BITS-1:0]   wr_addr;
   logic [WORD_BITS-1:0]  wr_data;
   logic [IDX_BITS-1:0]   rd_addr;
   logic [WORD_BITS-1:0]  rd_data;

   logic                  req_fire;
   logic [TIME_BITS-1:0]  rd_start, rd_end, cur_start;
   logic [CNT_BITS-1:0]   i_next, j_next, k_next;
   logic                  start_gt;

   assign req_fire  = req_chan.valid && req_chan.ready;
   assign rd_start  = rd_data[WORD_BITS-1:TIME_BITS];
   assign rd_end    = rd_data[TIME_BITS-1:0];
   assign cur_start = cur_ff[WORD_BITS-1:TIME_BITS];
   assign i_next    = CNT_BITS'(i_ff + 1'b1);
   assign j_next    = CNT_BITS'(j_ff + 1'b1);
   assign k_next    = CNT_BITS'(k_ff + 1'b1);
   // Shared sort comparator
   assign start_gt  = cur_start > rd_start;

   tris_pair_ram #(
      .DEPTH     (MAX_INTERVALS),
      .WIDTH     (WORD_BITS),
      .ADDR_BITS (IDX_BITS)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Hold sequencer state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         loaded_ff   <= '0;
         overflow_ff <= 1'b0;
         i_ff        <= '0;
         j_ff        <= '0;
         k_ff        <= '0;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         loaded_ff   <= loaded_in;
         overflow_ff <= overflow_in;
         i_ff        <= i_in;
         j_ff        <= j_in;
         k_ff        <= k_in;
         count_ff    <= count_in;
      end
   end

   // Hold datapath registers
   always_ff @(posedge clock) begin
      room1_ff <= room1_in;
      room2_ff <= room2_in;
      cur_ff   <= cur_in;
   end

   // Next state, store access and handshakes
   always_comb begin
      state_in    = state_ff;
      loaded_in   = loaded_ff;
      overflow_in = overflow_ff;
      i_in        = i_ff;
      j_in        = j_ff;
      k_in        = k_ff;
      count_in    = count_ff;
      room1_in    = room1_ff;
      room2_in    = room2_ff;
      cur_in      = cur_ff;
      wr_en       = 1'b0;
      wr_addr     = '0;
      wr_data     = cur_ff;
      rd_addr     = '0;

      case (state_ff)
         ST_LOAD: begin
            if (req_fire) begin
               // Store the word, or drop it when the store is full
               if (loaded_ff < CNT_BITS'(MAX_INTERVALS)) begin
                  wr_en     = 1'b1;
                  wr_addr   = loaded_ff[IDX_BITS-1:0];
                  wr_data   = {req_chan.start_time, req_chan.end_time};
                  loaded_in = CNT_BITS'(loaded_ff + 1'b1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_chan.last) begin
                  i_in     = '0;
                  state_in = ST_FETCH_I;
               end
            end
         end
         ST_FETCH_I: begin
            // Read entry i unless no later entry is left to compare
            if (i_next >= loaded_ff) begin
               state_in = ST_SCAN_START;
            end else begin
               rd_addr  = i_ff[IDX_BITS-1:0];
               j_in     = i_next;
               state_in = ST_LOAD_I;
            end
         end
         ST_LOAD_I: begin
            // Latch entry i as the running minimum, read entry j
            cur_in   = rd_data;
            rd_addr  = j_ff[IDX_BITS-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            // Swap the running entry with entry j when its start is greater
            if (start_gt) begin
               wr_en   = 1'b1;
               wr_addr = j_ff[IDX_BITS-1:0];
               wr_data = cur_ff;
               cur_in  = rd_data;
            end
            if (j_next < loaded_ff) begin
               rd_addr = j_next[IDX_BITS-1:0];
               j_in    = j_next;
            end else begin
               state_in = ST_WRITE_I;
            end
         end
         ST_WRITE_I: begin
            // Write back the settled entry i
            wr_en    = 1'b1;
            wr_addr  = i_ff[IDX_BITS-1:0];
            wr_data  = cur_ff;
            i_in     = i_next;
            state_in = ST_FETCH_I;
         end
         ST_SCAN_START: begin
            room1_in = '0;
            room2_in = '0;
            count_in = '0;
            k_in     = '0;
            rd_addr  = '0;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            // Place entry k greedily, room one first
            if (room1_ff <= rd_start) begin
               room1_in = rd_end;
               count_in = CNT_BITS'(count_ff + 1'b1);
            end else if (room2_ff <= rd_start) begin
               room2_in = rd_end;
               count_in = CNT_BITS'(count_ff + 1'b1);
            end
            if (k_next < loaded_ff) begin
               rd_addr = k_next[IDX_BITS-1:0];
               k_in    = k_next;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // Drop batch state once the result word is taken
            if (rsp_chan.ready) begin
               loaded_in   = '0;
               overflow_in = 1'b0;
               state_in    = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   assign req_chan.ready           = (state_ff == ST_LOAD);
   assign rsp_chan.valid           = (state_ff == ST_RESP);
   assign rsp_chan.scheduled_count = count_ff;
   assign rsp_chan.overflow        = overflow_ff;

   // Input and result sides are never open together
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_chan.ready && rsp_chan.valid))
      else $error("input accepted while result pending");

   // Store fill never passes capacity
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_BITS'(MAX_INTERVALS))
      else $error("fill count beyond capacity");

   // A result never counts more entries than were stored
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> count_ff <= loaded_ff)
      else $error("scheduled count exceeds stored entries");

   // A closing word starts the sort
   a_last_starts: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.last) |=> (state_ff == ST_FETCH_I && i_ff == '0))
      else $error("closing word did not start the sort");

   // Compare index always runs ahead of the settled index and inside the batch
   a_cmp_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP) |-> (j_ff > i_ff && j_ff < loaded_ff))
      else $error("sort indexes out of order");

endmodule

FILE: test/tris_count_checker.sv
// Checker for the two-room interval scheduler: predicts each batch count and compares results.
`timescale 1ns / 1ps

module tris_count_checker #(
   parameter int MAX_INTERVALS = 64,
   parameter int TIME_BITS     = 20,
   parameter int COUNT_BITS    = 7
) (
   input  logic clock,
   input  logic reset,
   tris_req_if  req_chan,
   tris_rsp_if  rsp_chan,
   output int   fail_count,
   output int   pending_results
);

   typedef struct packed {
      logic [COUNT_BITS-1:0] scheduled_count;
      logic                  overflow;
   } tally_type;

   logic [TIME_BITS-1:0] held_start [MAX_INTERVALS];
   logic [TIME_BITS-1:0] held_end   [MAX_INTERVALS];
   int                   held_count;
   logic                 dropped_seen;
   tally_type            tally_q [$];

   // Sort held intervals by start with the exchange pass, then place them over two rooms
   function automatic tally_type close_batch();
      logic [TIME_BITS-1:0] swap_word;
      logic [TIME_BITS-1:0] room_one_end;
      logic [TIME_BITS-1:0] room_two_end;
      int                   placed;
      tally_type            tally;
      for (int i = 0; i < held_count; i++) begin
         for (int j = i + 1; j < held_count; j++) begin
            if (held_start[i] > held_start[j]) begin
               swap_word     = held_start[i];
               held_start[i] = held_start[j];
               held_start[j] = swap_word;
               swap_word     = held_end[i];
               held_end[i]   = held_end[j];
               held_end[j]   = swap_word;
            end
         end
      end
      room_one_end = '0;
      room_two_end = '0;
      placed       = 0;
      for (int i = 0; i < held_count; i++) begin
         if (room_one_end <= held_start[i]) begin
            room_one_end = held_end[i];
            placed++;
         end else if (room_two_end <= held_start[i]) begin
            room_two_end = held_end[i];
            placed++;
         end
      end
      tally.scheduled_count = COUNT_BITS'(placed);
      tally.overflow        = dropped_seen;
      return tally;
   endfunction

   always @(posedge clock) begin : watch
      tally_type expected;
      if (reset) begin
         held_count   = 0;
         dropped_seen = 1'b0;
         fail_count   = 0;
         tally_q.delete();
      end else begin
         // Store the interval word, or flag it as dropped when the batch is full
         if (req_chan.valid && req_chan.ready) begin
            if (held_count < MAX_INTERVALS) begin
               held_start[held_count] = req_chan.start_time;
               held_end[held_count]   = req_chan.end_time;
               held_count++;
            end else begin
               dropped_seen = 1'b1;
            end
            // Close the batch: predict its count, then start the next one empty
            if (req_chan.last) begin
               tally_q.push_back(close_batch());
               held_count   = 0;
               dropped_seen = 1'b0;
            end
         end
         // Match the result word against the oldest prediction
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (tally_q.size() == 0) begin
               $display("%0t: result word with none expected: count %0d overflow %0b",
                        $time, rsp_chan.scheduled_count, rsp_chan.overflow);
               fail_count++;
            end else begin
               expected = tally_q.pop_front();
               if (rsp_chan.scheduled_count !== expected.scheduled_count) begin
                  $display("%0t: scheduled_count expected %0d, got %0d", $time,
                           expected.scheduled_count, rsp_chan.scheduled_count);
                  fail_count++;
               end
               if (rsp_chan.overflow !== expected.overflow) begin
                  $display("%0t: overflow expected %0b, got %0b", $time,
                           expected.overflow, rsp_chan.overflow);
                  fail_count++;
               end
            end
         end
      end
      pending_results <= tally_q.size();
   end

endmodule

FILE: test/two_room_interval_scheduler_top_tb.sv
// Testbench top for the two-room interval scheduler: stimulus, result stalls and verdict.
`timescale 1ns / 1ps

module two_room_interval_scheduler_top_tb;

   localparam int                   MAX_INTERVALS = 64;
   localparam int                   TIME_BITS     = 20;
   localparam int                   COUNT_BITS    = 7;
   localparam logic [TIME_BITS-1:0] TIME_MAX      = '1;
   localparam int                   RANDOM_WORDS  = 800;
   localparam int                   IDLE_LIMIT    = 20000;
   localparam int                   DRAIN_CYCLES  = 2500;

   // How random times are spread over the field
   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_EDGES
   } spread_type;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_results;
   bit   calm_stretch;
   int   words_sent;

   tris_req_if #(.TIME_BITS(TIME_BITS))   req_chan ();
   tris_rsp_if #(.COUNT_BITS(COUNT_BITS)) rsp_chan ();

   two_room_interval_scheduler_top #(
      .MAX_INTERVALS(MAX_INTERVALS),
      .TIME_BITS    (TIME_BITS)
   ) uut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan)
   );

   tris_count_checker #(
      .MAX_INTERVALS(MAX_INTERVALS),
      .TIME_BITS    (TIME_BITS),
      .COUNT_BITS   (COUNT_BITS)
   ) count_check (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan),
      .fail_count     (fail_count),
      .pending_results(pending_results)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Gap before a word: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (calm_stretch || roll < 55) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [TIME_BITS-1:0] pick_time(input spread_type spread);
      case (spread)
         SPREAD_FULL:   return TIME_BITS'($urandom());
         SPREAD_NARROW: return TIME_BITS'($urandom_range(0, 31));
         default: begin
            case ($urandom_range(0, 3))
               0:       return '0;
               1:       return TIME_BITS'(1);
               2:       return TIME_MAX - 1'b1;
               default: return TIME_MAX;
            endcase
         end
      endcase
   endfunction

   // Offer one interval word and hold it until the block takes it
   task automatic send_word(input logic [TIME_BITS-1:0] start_word,
                            input logic [TIME_BITS-1:0] end_word, input logic last_word);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_chan.start_time <= start_word;
      req_chan.end_time   <= end_word;
      req_chan.last       <= last_word;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   // Send one batch of random intervals, mostly short ones with some ends before starts
   task automatic send_batch(input int length, input spread_type spread);
      logic [TIME_BITS-1:0] start_word;
      logic [TIME_BITS-1:0] end_word;
      for (int k = 0; k < length; k++) begin
         start_word = pick_time(spread);
         if ($urandom_range(0, 3) == 0) end_word = pick_time(spread);
         else end_word = start_word + TIME_BITS'($urandom_range(0, 12));
         send_word(start_word, end_word, k == length - 1);
         words_sent++;
      end
   endtask

   // Result side: hold ready high or low for random stretches
   initial begin : result_sink
      int hold;
      int roll;
      rsp_chan.ready <= 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (hold > 0) begin
            hold--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(1, 20);
            end else if (roll < 60) begin
               rsp_chan.ready <= 1'b1;
               hold = $urandom_range(50, 300);
            end else if (roll < 90) begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(0, 3);
            end else begin
               rsp_chan.ready <= 1'b0;
               hold = $urandom_range(10, 40);
            end
         end
      end
   end

   // Stop the run when no word moves on either channel for too long
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("two_room_interval_scheduler_top_tb NOT OK");
      $finish;
   end

   initial begin : stimulus
      int length;
      int roll;
      reset               <= 1'b1;
      req_chan.valid      <= 1'b0;
      req_chan.start_time <= '0;
      req_chan.end_time   <= '0;
      req_chan.last       <= 1'b0;
      calm_stretch = 1'b0;
      words_sent   = 0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Single intervals at the field extremes
      send_word('0, '0, 1'b1);
      send_word(TIME_MAX, TIME_MAX, 1'b1);
      // End before start is taken as given
      send_word(20'd10, 20'd3, 1'b0);
      send_word(20'd4, 20'd20, 1'b0);
      send_word(20'd5, 20'd6, 1'b1);
      // Equal starts: the exchange pass decides which end each room gets
      send_word(20'd7, 20'd9, 1'b0);
      send_word(20'd7, 20'd12, 1'b0);
      send_word(20'd7, 20'd8, 1'b1);
      // Both rooms blocked to the end of time
      send_word('0, TIME_MAX, 1'b0);
      send_word('0, TIME_MAX, 1'b0);
      send_word(20'd1, 20'd5, 1'b1);
      // Unsorted arrival order with back-to-back fits
      send_word(20'd30, 20'd40, 1'b0);
      send_word(20'd10, 20'd20, 1'b0);
      send_word(20'd20, 20'd30, 1'b0);
      send_word(20'd0, 20'd10, 1'b0);
      send_word(20'd15, 20'd25, 1'b1);

      // Random batches: mostly short, some mid-size, a few near, at or past capacity
      while (words_sent < RANDOM_WORDS) begin
         calm_stretch = ($urandom_range(0, 3) == 0);
         roll = $urandom_range(0, 99);
         if (roll < 8) begin
            case ($urandom_range(0, 4))
               0:       length = MAX_INTERVALS - 1;
               1:       length = MAX_INTERVALS;
               2:       length = MAX_INTERVALS + 1;
               3:       length = MAX_INTERVALS + 2;
               default: length = MAX_INTERVALS + 6;
            endcase
         end else if (roll < 18) begin
            length = $urandom_range(11, MAX_INTERVALS - 1);
         end else begin
            length = $urandom_range(1, 10);
         end
         send_batch(length, spread_type'($urandom_range(0, 2)));
      end
      req_chan.valid <= 1'b0;

      // Drain: wait for every predicted result, then let the block settle
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("two_room_interval_scheduler_top_tb OK");
      else
         $display("two_room_interval_scheduler_top_tb NOT OK");
      $finish;
   end

endmodule
